// File: rtl/radix2_fft_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix-2 FFT engine
// Shared clocking and reset qualification for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_ENGINE_UNIT_DEFINES_SVH
`define RADIX2_FFT_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define R2FFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset
`define R2FFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Constants, types and the twiddle table builder for the radix-2 FFT engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package r2fft_pkg;

  localparam int MAX_POINTS   = 2048;
  localparam int LOG_MAX      = 11;
  localparam int IDX_W        = 11;
  localparam int CNT_W        = IDX_W + 1;
  localparam int LOG_W        = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 18;
  localparam int TW_FRAC      = TWIDDLE_BITS - 1;
  localparam int BIN_W        = 28;
  localparam int ENTRY_W      = 2 * BIN_W;
  localparam int TW_DEPTH     = MAX_POINTS / 2;
  localparam int TW_AW        = LOG_MAX - 1;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 56;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB,
    ST_COPY
  } state_e;

  // Step strobes from the sequencer to the butterfly unit
  typedef struct packed {
    logic tw_rd;
    logic mul_en;
    logic add_en;
  } bf_ctl_t;

  typedef logic signed [TWIDDLE_BITS-1:0] tw_rom_t [TW_DEPTH];

  // Quotient by shift and subtract, used only while building the constant tables
  function automatic longint unsigned udiv_const(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Build the cosine or sine table from a Q30 Taylor series, folded to [0, pi/2]
  function automatic tw_rom_t tw_build(input logic want_sin);
    tw_rom_t tbl;
    longint unsigned kk, x, x2, tc, ts, d;
    longint sc, ss, v;
    logic fold;
    for (int k = 0; k < TW_DEPTH; k++) begin
      fold = (4 * k > MAX_POINTS);
      kk = fold ? 64'(MAX_POINTS / 2 - k) : 64'(k);
      x = (kk * 64'd4 * HALF_PI_Q30 + 64'(MAX_POINTS / 2)) >> LOG_MAX;
      x2 = (x * x) >> 30;
      tc = 64'd1 << 30;
      ts = x;
      sc = longint'(tc);
      ss = longint'(ts);
      for (int n = 0; n < 13; n++) begin
        d = 64'((2 * n + 1) * (2 * n + 2));
        tc = udiv_const((tc * x2) >> 30, d);
        d = 64'((2 * n + 2) * (2 * n + 3));
        ts = udiv_const((ts * x2) >> 30, d);
        if (n[0]) begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end else begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end
      end
      v = want_sin ? ss : sc;
      if (v < 0) v = 0;
      v = (v + (64'sd1 <<< (30 - TW_FRAC - 1))) >>> (30 - TW_FRAC);
      if (v > (64'sd1 <<< TW_FRAC) - 1) v = (64'sd1 <<< TW_FRAC) - 1;
      if (!want_sin && fold) v = -v;
      tbl[k] = TWIDDLE_BITS'(v);
    end
    return tbl;
  endfunction

endpackage

// File: rtl/r2fft_bfly.sv
// ----------------------------------------------------------------------------
// r2fft_bfly
// Shared radix-2 butterfly: twiddle ROM, complex multiply, round, add/sub.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2fft_bfly (
  input  logic                                  clk_i,
  input  r2fft_pkg::bf_ctl_t                    ctl_i,
  input  logic [r2fft_pkg::TW_AW-1:0]           tw_addr_i,
  input  logic signed [r2fft_pkg::BIN_W-1:0]    a_re_i,
  input  logic signed [r2fft_pkg::BIN_W-1:0]    a_im_i,
  input  logic signed [r2fft_pkg::BIN_W-1:0]    b_re_i,
  input  logic signed [r2fft_pkg::BIN_W-1:0]    b_im_i,
  output logic signed [r2fft_pkg::BIN_W-1:0]    sum_re_o,
  output logic signed [r2fft_pkg::BIN_W-1:0]    sum_im_o,
  output logic signed [r2fft_pkg::BIN_W-1:0]    dif_re_o,
  output logic signed [r2fft_pkg::BIN_W-1:0]    dif_im_o
);
  import r2fft_pkg::*;

  localparam int PROD_W = BIN_W + TWIDDLE_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam int T_W    = ACC_W - TW_FRAC;
  localparam int SUM_W  = T_W + 1;
  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) <<< (TW_FRAC - 1);
  localparam logic signed [SUM_W-1:0] BIN_MAX = (SUM_W'(1) <<< (BIN_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0] BIN_MIN = -(SUM_W'(1) <<< (BIN_W - 1));
  localparam tw_rom_t TW_COS = tw_build(1'b0);
  localparam tw_rom_t TW_SIN = tw_build(1'b1);

  logic signed [TWIDDLE_BITS-1:0] cos_q, sin_q;
  logic signed [PROD_W-1:0]       prc_q, pis_q, pic_q, prs_q;
  logic signed [BIN_W-1:0]        are_q, aim_q;
  logic signed [T_W-1:0]          tre_q, tim_q;
  logic signed [ACC_W-1:0]        acc_re, acc_im;
  logic signed [SUM_W-1:0]        s_re, s_im, d_re, d_im;

  function automatic logic signed [BIN_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    if (v > BIN_MAX) return BIN_MAX[BIN_W-1:0];
    if (v < BIN_MIN) return BIN_MIN[BIN_W-1:0];
    return v[BIN_W-1:0];
  endfunction

  // Fetch the twiddle pair
  always_ff @(posedge clk_i) begin
    if (ctl_i.tw_rd) begin
      cos_q <= TW_COS[tw_addr_i];
      sin_q <= TW_SIN[tw_addr_i];
    end
  end

  // Form the four partial products and hold the upper input
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prc_q <= b_re_i * cos_q;
      pis_q <= b_im_i * sin_q;
      pic_q <= b_im_i * cos_q;
      prs_q <= b_re_i * sin_q;
      are_q <= a_re_i;
      aim_q <= a_im_i;
    end
  end

  // Combine and round half up
  assign acc_re = ACC_W'(prc_q) + ACC_W'(pis_q) + RND;
  assign acc_im = ACC_W'(pic_q) - ACC_W'(prs_q) + RND;

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_en) begin
      tre_q <= T_W'(acc_re >>> TW_FRAC);
      tim_q <= T_W'(acc_im >>> TW_FRAC);
    end
  end

  // Saturating sum and difference
  assign s_re = SUM_W'(are_q) + SUM_W'(tre_q);
  assign s_im = SUM_W'(aim_q) + SUM_W'(tim_q);
  assign d_re = SUM_W'(are_q) - SUM_W'(tre_q);
  assign d_im = SUM_W'(aim_q) - SUM_W'(tim_q);

  assign sum_re_o = sat(s_re);
  assign sum_im_o = sat(s_im);
  assign dif_re_o = sat(d_re);
  assign dif_im_o = sat(d_im);

endmodule

// File: rtl/radix2_fft_engine_unit.sv
// ----------------------------------------------------------------------------
// radix2_fft_engine_unit
// Forward complex radix-2 DIT FFT with a point store and write, run and read beats.
// ----------------------------------------------------------------------------
// A write beat or an out-of-range beat loads its result straight from the idle
// state; an in-range read beat passes the read state first. A run beat starts a
// bit-reversed load that sweeps the whole mark store and clears it, then runs the
// (N/2)*log2(N) butterflies through read, multiply, add and a write state for each
// leg, one at a time on the shared butterfly unit and single work write port, then
// copies the bins back. After reset a clearing pass zeroes every store entry and
// its mark before the first beat is taken.
`timescale 1ns / 1ps

module radix2_fft_engine_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: index[10:0], sample_real[26:11], sample_imag[42:27], zero pad
  input  logic [r2fft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]                           s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: bin_real[27:0], bin_imag[55:28]
  output logic [r2fft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: status[0]
  output logic [0:0]                           m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [r2fft_pkg::LOG_W-1:0]          cfg_wdata_i
);
  import r2fft_pkg::*;
  `include "radix2_fft_engine_unit_defines.svh"

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [TW_AW-1:0] j_q, j_d;
  logic [LOG_W-1:0] stg_q, stg_d;
  logic [LOG_W-1:0] log_size_q;
  logic             ov_q, ov_d;
  logic             ld_out;
  logic [BIN_W-1:0] o_re_q, o_im_q, o_re_d, o_im_d;
  logic             o_st_q, o_st_d;

  // Input beat fields
  mode_e                   in_mode;
  logic [IDX_W-1:0]        in_idx;
  logic [SAMPLE_BITS-1:0]  in_re, in_im;
  logic                    in_range, accept;

  // Effective length
  logic [LOG_W-1:0] lg;
  logic [CNT_W-1:0] n_pts, half_n;

  // Butterfly addressing
  logic [IDX_W-1:0] half, hmask, j11, bp, bq, tw11, rev, rev_s;

  // Memories and their ports
  logic [ENTRY_W-1:0] store_mem [MAX_POINTS];
  logic               mark_mem  [MAX_POINTS];
  logic [ENTRY_W-1:0] work_mem  [MAX_POINTS];
  logic [ENTRY_W-1:0] store_rd_q, wk_rd_a_q, wk_rd_b_q;
  logic               mark_rd_q;
  logic               st_we, st_re, mk_we, wk_we, wk_re;
  logic [IDX_W-1:0]   st_wa, st_ra, mk_wa, wk_wa, wk_ra_a, wk_ra_b;
  logic [ENTRY_W-1:0] st_wd, wk_wd;
  logic               mk_wd;

  bf_ctl_t          bf_ctl;
  logic [BIN_W-1:0] sum_re, sum_im, dif_re, dif_im;

  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_re    = s_axis_tdata[IDX_W +: SAMPLE_BITS];
  assign in_im    = s_axis_tdata[IDX_W+SAMPLE_BITS +: SAMPLE_BITS];
  assign in_range = {1'b0, in_idx} < n_pts;
  assign s_axis_tready = (state_q == ST_IDLE) && (!ov_q || m_axis_tready);
  assign accept   = s_axis_tvalid && s_axis_tready;

  // Clamp the length register into the supported range
  always_comb begin
    if (log_size_q == '0) begin
      lg = LOG_W'(1);
    end else if (log_size_q > LOG_W'(LOG_MAX)) begin
      lg = LOG_W'(LOG_MAX);
    end else begin
      lg = log_size_q;
    end
  end
  assign n_pts  = CNT_W'(1) << lg;
  assign half_n = n_pts >> 1;

  // Insert a zero at the stage bit to get the upper leg, set it for the lower
  assign half  = IDX_W'(1) << (stg_q - LOG_W'(1));
  assign hmask = half - IDX_W'(1);
  assign j11   = {1'b0, j_q};
  assign bp    = ((j11 & ~hmask) << 1) | (j11 & hmask);
  assign bq    = bp | half;
  assign tw11  = (j11 & hmask) << (LOG_W'(LOG_MAX) - stg_q);

  // Bit-reverse the loaded index within lg bits
  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      rev[b] = pidx_q[IDX_W-1-b];
    end
  end
  assign rev_s = rev >> (LOG_W'(IDX_W) - lg);

  // Point store and write marks
  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_wa] <= st_wd;
    if (st_re) store_rd_q <= store_mem[st_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    if (st_re) mark_rd_q <= mark_mem[st_ra];
  end

  // Work memory: one write port, two read ports
  always_ff @(posedge clk_i) begin
    if (wk_we) work_mem[wk_wa] <= wk_wd;
    if (wk_re) begin
      wk_rd_a_q <= work_mem[wk_ra_a];
      wk_rd_b_q <= work_mem[wk_ra_b];
    end
  end

  r2fft_bfly u_bfly (
    .clk_i     (clk_i),
    .ctl_i     (bf_ctl),
    .tw_addr_i (tw11[TW_AW-1:0]),
    .a_re_i    (wk_rd_a_q[BIN_W-1:0]),
    .a_im_i    (wk_rd_a_q[ENTRY_W-1:BIN_W]),
    .b_re_i    (wk_rd_b_q[BIN_W-1:0]),
    .b_im_i    (wk_rd_b_q[ENTRY_W-1:BIN_W]),
    .sum_re_o  (sum_re),
    .sum_im_o  (sum_im),
    .dif_re_o  (dif_re),
    .dif_im_o  (dif_im)
  );

  // Sequencer: next state, counters, memory strobes
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pv_d    = 1'b0;
    pidx_d  = pidx_q;
    j_d     = j_q;
    stg_d   = stg_q;
    ov_d    = ov_q && !m_axis_tready;
    ld_out  = 1'b0;
    o_re_d  = '0;
    o_im_d  = '0;
    o_st_d  = 1'b0;
    st_we   = 1'b0;
    st_re   = 1'b0;
    st_wa   = cnt_q[IDX_W-1:0];
    st_ra   = in_idx;
    st_wd   = '0;
    mk_we   = 1'b0;
    mk_wa   = cnt_q[IDX_W-1:0];
    mk_wd   = 1'b0;
    wk_we   = 1'b0;
    wk_re   = 1'b0;
    wk_wa   = bp;
    wk_wd   = {sum_im, sum_re};
    wk_ra_a = bp;
    wk_ra_b = bq;
    bf_ctl  = '0;

    case (state_q)
      ST_CLEAR: begin
        // Zero one store entry and its mark per cycle
        st_we = 1'b1;
        mk_we = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_POINTS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_WRITE: begin
              ov_d   = 1'b1;
              ld_out = 1'b1;
              o_st_d = !in_range;
              if (in_range) begin
                st_we = 1'b1;
                st_wa = in_idx;
                st_wd = {{(BIN_W-SAMPLE_BITS){in_im[SAMPLE_BITS-1]}}, in_im,
                         {(BIN_W-SAMPLE_BITS){in_re[SAMPLE_BITS-1]}}, in_re};
                mk_we = 1'b1;
                mk_wa = in_idx;
                mk_wd = 1'b1;
              end
            end
            MODE_READ: begin
              if (in_range) begin
                st_re   = 1'b1;
                state_d = ST_READ;
              end else begin
                ov_d   = 1'b1;
                ld_out = 1'b1;
                o_st_d = 1'b1;
              end
            end
            MODE_RUN: begin
              cnt_d   = '0;
              state_d = ST_LOAD;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        ov_d    = 1'b1;
        ld_out  = 1'b1;
        o_re_d  = store_rd_q[BIN_W-1:0];
        o_im_d  = store_rd_q[ENTRY_W-1:BIN_W];
        state_d = ST_IDLE;
      end

      ST_LOAD: begin
        // Sweep every mark; the first N entries go bit-reversed into work
        if (!cnt_q[IDX_W]) begin
          st_re  = 1'b1;
          st_ra  = cnt_q[IDX_W-1:0];
          mk_we  = 1'b1;
          pv_d   = 1'b1;
          pidx_d = cnt_q[IDX_W-1:0];
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          stg_d   = LOG_W'(1);
          j_d     = '0;
          state_d = ST_BF_RD;
        end
        if (pv_q && ({1'b0, pidx_q} < n_pts)) begin
          wk_we = 1'b1;
          wk_wa = rev_s;
          wk_wd = mark_rd_q ? store_rd_q : '0;
        end
      end

      ST_BF_RD: begin
        wk_re        = 1'b1;
        bf_ctl.tw_rd = 1'b1;
        state_d      = ST_BF_MUL;
      end

      ST_BF_MUL: begin
        bf_ctl.mul_en = 1'b1;
        state_d       = ST_BF_ADD;
      end

      ST_BF_ADD: begin
        bf_ctl.add_en = 1'b1;
        state_d       = ST_BF_WA;
      end

      ST_BF_WA: begin
        wk_we   = 1'b1;
        state_d = ST_BF_WB;
      end

      ST_BF_WB: begin
        // Write the lower leg, then advance butterfly and stage
        wk_we   = 1'b1;
        wk_wa   = bq;
        wk_wd   = {dif_im, dif_re};
        state_d = ST_BF_RD;
        if (j11 == half_n[IDX_W-1:0] - IDX_W'(1)) begin
          j_d = '0;
          if (stg_q == lg) begin
            cnt_d   = '0;
            state_d = ST_COPY;
          end else begin
            stg_d = stg_q + LOG_W'(1);
          end
        end else begin
          j_d = j_q + TW_AW'(1);
        end
      end

      ST_COPY: begin
        // Move the bins back to the store in natural order
        if (cnt_q != n_pts) begin
          wk_re   = 1'b1;
          wk_ra_a = cnt_q[IDX_W-1:0];
          pv_d    = 1'b1;
          pidx_d  = cnt_q[IDX_W-1:0];
          cnt_d   = cnt_q + CNT_W'(1);
        end else begin
          ov_d    = 1'b1;
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
        if (pv_q) begin
          st_we = 1'b1;
          st_wa = pidx_q;
          st_wd = wk_rd_a_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      j_q        <= '0;
      stg_q      <= LOG_W'(1);
      ov_q       <= 1'b0;
      log_size_q <= LOG_W'(LOG_MAX);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      pidx_q  <= pidx_d;
      j_q     <= j_d;
      stg_q   <= stg_d;
      ov_q    <= ov_d;
      if (cfg_we_i) log_size_q <= cfg_wdata_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      o_re_q <= o_re_d;
      o_im_q <= o_im_d;
      o_st_q <= o_st_d;
    end
  end

  assign m_axis_tvalid   = ov_q;
  assign m_axis_tdata    = {o_im_q, o_re_q};
  assign m_axis_tuser[0] = o_st_q;

  `R2FFT_ASSERT_NOW(a_busy_blocks_input, state_q != ST_IDLE, !s_axis_tready,
                    "input taken while sequencer busy")
  `R2FFT_ASSERT_NEXT(a_run_enters_load, accept && in_mode == MODE_RUN,
                     state_q == ST_LOAD, "run beat did not start the load sweep")
  `R2FFT_ASSERT_NOW(a_bfly_legs_pair, state_q == ST_BF_WA,
                    (bp & half) == '0 && bq == (bp | half) && stg_q <= lg,
                    "butterfly legs do not form a stage pair")

endmodule
